>>> sv/tfn_pkg.sv
// Shared types and widths for the triangle face normal block.
// No dependencies; every other file imports this package.
package tfn_pkg;

    // Width of a cross-product component (|n| < 2^33, signed)
    localparam int CW = 34;
    // Width of the working words of the normalization search
    localparam int WW = 104;
    // Bits of the rounded magnitude (0 .. 16384)
    localparam int QW = 15;
    // Number of search steps, one per magnitude bit
    localparam int NSTEP = 15;

    // Input word: three vertices in signed Q4.12
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] bx;
        logic signed [15:0] by_coord;
        logic signed [15:0] bz;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
    } t_tri_in;

    // Result word: unit normal in signed Q1.14 plus degenerate flag
    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               degenerate;
    } t_norm_out;

    // Exact cross product handed from front to back
    typedef struct packed {
        logic signed [CW-1:0] nx;
        logic signed [CW-1:0] ny;
        logic signed [CW-1:0] nz;
    } t_cross;

endpackage

>>> sv/tfn_front.sv
// Front end: registers accepted triangles, forms edges and the exact cross product.
// Depends on tfn_pkg.
module tfn_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  tfn_pkg::t_tri_in i_tri,
    output logic            o_push,
    output tfn_pkg::t_cross o_cross,
    output logic [1:0]      o_fill
);
    import tfn_pkg::*;

    logic                r1_vld, r2_vld, r3_vld;
    logic signed [16:0]  r1_e1x, r1_e1y, r1_e1z, r1_e2x, r1_e2y, r1_e2z;
    logic signed [CW-1:0] r2_p [0:5];
    t_cross              r3_cross;

    // Advance the valid bits of the three front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_accept;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    // Edge vectors E1 = B - A, E2 = C - B
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r1_e1x <= 17'(i_tri.bx) - 17'(i_tri.ax);
            r1_e1y <= 17'(i_tri.by_coord) - 17'(i_tri.ay);
            r1_e1z <= 17'(i_tri.bz) - 17'(i_tri.az);
            r1_e2x <= 17'(i_tri.cx) - 17'(i_tri.bx);
            r1_e2y <= 17'(i_tri.cy) - 17'(i_tri.by_coord);
            r1_e2z <= 17'(i_tri.cz) - 17'(i_tri.bz);
        end
    end

    // Six partial products of the cross product
    always_ff @(posedge i_clk) begin
        r2_p[0] <= CW'(r1_e1y * r1_e2z);
        r2_p[1] <= CW'(r1_e1z * r1_e2y);
        r2_p[2] <= CW'(r1_e1z * r1_e2x);
        r2_p[3] <= CW'(r1_e1x * r1_e2z);
        r2_p[4] <= CW'(r1_e1x * r1_e2y);
        r2_p[5] <= CW'(r1_e1y * r1_e2x);
    end

    // Subtract pairs to finish each component
    always_ff @(posedge i_clk) begin
        r3_cross.nx <= r2_p[0] - r2_p[1];
        r3_cross.ny <= r2_p[2] - r2_p[3];
        r3_cross.nz <= r2_p[4] - r2_p[5];
    end

    assign o_push  = r3_vld;
    assign o_cross = r3_cross;
    assign o_fill  = 2'({1'b0, r1_vld} + {1'b0, r2_vld} + {1'b0, r3_vld});

endmodule

>>> sv/tfn_queue.sv
// Short queue between front and back; registered read data.
// Depends on tfn_pkg.
module tfn_queue #(
    parameter int DEPTH = 8,
    parameter int CNTW  = $clog2(DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tfn_pkg::t_cross i_cross,
    output logic            o_vld,
    output tfn_pkg::t_cross o_cross,
    output logic [CNTW-1:0] o_count
);
    import tfn_pkg::*;

    localparam int PW = $clog2(DEPTH);

    t_cross          r_mem [0:DEPTH-1];
    t_cross          r_rd_data;
    logic [PW-1:0]   r_wp, r_rp;
    logic [CNTW-1:0] r_cnt;
    logic            r_rd_vld;
    logic            w_pop;

    // Drain a word every cycle that one is stored
    assign w_pop = (r_cnt != '0);

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt    <= r_cnt + CNTW'(i_push) - CNTW'(w_pop);
            r_rd_vld <= w_pop;
        end
    end

    // Write and read the storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cross;
        end
        if (w_pop) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    assign o_vld   = r_rd_vld;
    assign o_cross = r_rd_data;
    assign o_count = r_cnt;

endmodule

>>> sv/tfn_back.sv
// Back end: squares, squared length and a pipelined exact rounded normalization.
// Depends on tfn_pkg.
module tfn_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  tfn_pkg::t_cross    i_cross,
    output logic               o_done,
    output tfn_pkg::t_norm_out o_normal
);
    import tfn_pkg::*;

    // Split squaring stage
    logic            r1_vld, r1_deg;
    logic [2:0]      r1_neg;
    logic [33:0]     r1_hh [0:2];
    logic [32:0]     r1_hl [0:2];
    logic [31:0]     r1_ll [0:2];
    // Square and sum stage
    logic            r2_vld, r2_deg;
    logic [2:0]      r2_neg;
    logic [65:0]     r2_sq [0:2];
    logic [67:0]     r2_s;
    // Search stages: index 0 is the start point
    logic                 r_vld  [0:NSTEP];
    logic                 r_deg  [0:NSTEP];
    logic [2:0]           r_neg  [0:NSTEP];
    logic [WW-1:0]        r_sw   [0:NSTEP];
    logic signed [WW-1:0] r_rem  [0:NSTEP][0:2];
    logic signed [WW-1:0] r_dsum [0:NSTEP][0:2];
    logic [QW-1:0]        r_q    [0:NSTEP][0:2];
    // Output register
    logic      r_done;
    t_norm_out r_out;

    logic signed [CW-1:0] w_n   [0:2];
    logic [CW-2:0]        w_mag [0:2];

    assign w_n[0] = i_cross.nx;
    assign w_n[1] = i_cross.ny;
    assign w_n[2] = i_cross.nz;

    // Take magnitudes of the components
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_mag[l] = w_n[l][CW-1] ? (CW-1)'(-w_n[l]) : (CW-1)'(w_n[l]);
        end
    end

    // Advance valid bits of the fixed stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld   <= 1'b0;
            r2_vld   <= 1'b0;
            r_vld[0] <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r1_vld   <= i_vld;
            r2_vld   <= r1_vld;
            r_vld[0] <= r2_vld;
            r_done   <= r_vld[NSTEP];
        end
    end

    // Split each magnitude into high and low halves and multiply the parts
    always_ff @(posedge i_clk) begin
        r1_deg <= (w_n[0] == '0) && (w_n[1] == '0) && (w_n[2] == '0);
        for (int l = 0; l < 3; l++) begin
            r1_neg[l] <= w_n[l][CW-1];
            r1_hh[l]  <= w_mag[l][32:16] * w_mag[l][32:16];
            r1_hl[l]  <= w_mag[l][32:16] * {1'b0, w_mag[l][15:0]};
            r1_ll[l]  <= w_mag[l][15:0] * w_mag[l][15:0];
        end
    end

    // Combine parts into exact squares and the squared length
    always_ff @(posedge i_clk) begin
        logic [65:0] sq [0:2];
        for (int l = 0; l < 3; l++) begin
            sq[l] = {r1_hh[l], 32'b0} + {16'b0, r1_hl[l], 17'b0} + {34'b0, r1_ll[l]};
        end
        r2_deg <= r1_deg;
        r2_neg <= r1_neg;
        for (int l = 0; l < 3; l++) begin
            r2_sq[l] <= sq[l];
        end
        r2_s <= 68'(sq[0]) + 68'(sq[1]) + 68'(sq[2]);
    end

    // Start the search at q = 0: rem = c^2*2^30 - S, dsum = -S
    always_ff @(posedge i_clk) begin
        r_deg[0] <= r2_deg;
        r_neg[0] <= r2_neg;
        r_sw[0]  <= WW'(r2_s);
        for (int l = 0; l < 3; l++) begin
            r_rem[0][l]  <= (WW'(r2_sq[l]) << 30) - WW'(r2_s);
            r_dsum[0][l] <= WW'(0) - WW'(r2_s);
            r_q[0][l]    <= '0;
        end
    end

    // One magnitude bit per stage, most significant first
    for (genvar k = 1; k <= NSTEP; k++) begin : g_step
        localparam int B = NSTEP - k;

        logic signed [WW-1:0] t_try  [0:2];
        logic signed [WW-1:0] n_rem  [0:2];
        logic signed [WW-1:0] n_dsum [0:2];
        logic [QW-1:0]        n_q    [0:2];

        // Try q + 2^B; keep it when (2q'-1)^2*S stays within c^2*2^30
        always_comb begin
            for (int l = 0; l < 3; l++) begin
                t_try[l]  = r_rem[k-1][l] - (r_dsum[k-1][l] << (B + 2))
                            - signed'(r_sw[k-1] << (2 * B + 2));
                n_rem[l]  = r_rem[k-1][l];
                n_dsum[l] = r_dsum[k-1][l];
                n_q[l]    = r_q[k-1][l];
                if (!((B < QW - 1) && r_q[k-1][l][QW-1]) && !t_try[l][WW-1]) begin
                    n_rem[l]  = t_try[l];
                    n_dsum[l] = r_dsum[k-1][l] + signed'(r_sw[k-1] << (B + 1));
                    n_q[l]    = r_q[k-1][l] | QW'(1 << B);
                end
            end
        end

        // Advance the valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        // Hold the stage payload
        always_ff @(posedge i_clk) begin
            r_deg[k] <= r_deg[k-1];
            r_neg[k] <= r_neg[k-1];
            r_sw[k]  <= r_sw[k-1];
            for (int l = 0; l < 3; l++) begin
                r_rem[k][l]  <= n_rem[l];
                r_dsum[k][l] <= n_dsum[l];
                r_q[k][l]    <= n_q[l];
            end
        end
    end

    // Apply signs, force zero on a degenerate triangle
    always_ff @(posedge i_clk) begin
        logic signed [15:0] v [0:2];
        for (int l = 0; l < 3; l++) begin
            v[l] = r_neg[NSTEP][l] ? -$signed({1'b0, r_q[NSTEP][l]})
                                   : $signed({1'b0, r_q[NSTEP][l]});
            if (r_deg[NSTEP]) begin
                v[l] = '0;
            end
        end
        r_out.nx         <= v[0];
        r_out.ny         <= v[1];
        r_out.nz         <= v[2];
        r_out.degenerate <= r_deg[NSTEP];
    end

    assign o_done   = r_done;
    assign o_normal = r_out;

endmodule

>>> sv/triangle_face_normal.sv
// Top level of the triangle face normal block: front, queue and back joined.
// Depends on tfn_pkg, tfn_front, tfn_queue and tfn_back.
//
//  channel   signals                  direction  handshake
//  triangle  start, busy, i_tri       in         taken when start & !busy
//  normal    o_done, o_normal         out        one-cycle strobe, no stall
//
// One triangle per clock sustained while busy is low; the fifteen-step
// normalization pipeline in the back end resolves one bit of each
// component's magnitude per stage.
// busy rises only when words in the front stages and the queue fill the queue
// depth; the back end drains a word every cycle, so busy stays low in steady use.
// Reset is synchronous and clears all valid bits; no clearing pass is needed.
module triangle_face_normal #(
    parameter int QDEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tfn_pkg::t_tri_in   i_tri,
    output logic               o_done,
    output tfn_pkg::t_norm_out o_normal
);
    import tfn_pkg::*;

    localparam int QCW = $clog2(QDEPTH + 1);
    localparam int UW  = QCW + 1;

    logic           w_accept, w_push, w_qvld;
    logic [1:0]     w_ffill;
    logic [QCW-1:0] w_qcount;
    logic [UW-1:0]  w_used;
    t_cross         w_fcross, w_qcross;

    // Hold off new words while the queue could not absorb those in flight
    assign w_used   = UW'(w_qcount) + UW'(w_ffill);
    assign busy     = (w_used >= UW'(QDEPTH));
    assign w_accept = start && !busy;

    tfn_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_tri    (i_tri),
        .o_push   (w_push),
        .o_cross  (w_fcross),
        .o_fill   (w_ffill)
    );

    tfn_queue #(
        .DEPTH (QDEPTH),
        .CNTW  (QCW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cross (w_fcross),
        .o_vld   (w_qvld),
        .o_cross (w_qcross),
        .o_count (w_qcount)
    );

    tfn_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_qvld),
        .i_cross  (w_qcross),
        .o_done   (o_done),
        .o_normal (o_normal)
    );

    // A push never lands on a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_qcount < QCW'(QDEPTH)))
        else $error("queue overflow");

    // A degenerate result carries a zero vector
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_normal.degenerate) |->
        (o_normal.nx == 16'sd0 && o_normal.ny == 16'sd0 && o_normal.nz == 16'sd0))
        else $error("degenerate result not zero");

    // Components stay within plus or minus one
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |->
        (o_normal.nx <= 16'sd16384 && o_normal.nx >= -16'sd16384 &&
         o_normal.ny <= 16'sd16384 && o_normal.ny >= -16'sd16384 &&
         o_normal.nz <= 16'sd16384 && o_normal.nz >= -16'sd16384))
        else $error("normal component out of range");

endmodule
